// ===== rtl/awc_pkg.sv =====
// Package for the autorange window check block.
// Holds the register map, the status codes and the configuration struct.
// No dependencies.
package awc_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned LEVEL_W = 15;
   localparam int unsigned SPAN_W = 16;
   localparam int unsigned LIMIT_W = 10;
   localparam int unsigned COOLDOWN_W = 16;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OVER_LEVEL = 2'd0,
      REG_UNDER_SPAN = 2'd1,
      REG_OVER_COUNT_LIMIT = 2'd2,
      REG_COOLDOWN_PAGES = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_NORMAL = 2'd0,
      STATUS_OVER = 2'd1,
      STATUS_UNDER = 2'd2
   } range_status_type;

   localparam logic [LEVEL_W-1:0] OVER_LEVEL_RESET = 15'd1843;
   localparam logic [SPAN_W-1:0] UNDER_SPAN_RESET = 16'd614;
   localparam logic [LIMIT_W-1:0] OVER_COUNT_LIMIT_RESET = 10'd11;
   localparam logic [COOLDOWN_W-1:0] COOLDOWN_PAGES_RESET = 16'd10;

   typedef struct packed {
      logic [LEVEL_W-1:0] over_level;
      logic [SPAN_W-1:0] under_span;
      logic [LIMIT_W-1:0] over_count_limit;
      logic [COOLDOWN_W-1:0] cooldown_pages;
   } cfg_type;

endpackage

// ===== rtl/awc_page_track.sv =====
// Page state of the autorange window check: overrange count, minimum,
// maximum, page start flag and report cooldown, plus the page decision.
// Depends on awc_pkg.
module awc_page_track (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic signed [awc_pkg::SAMPLE_W-1:0] sample,
   input  logic last,
   input  awc_pkg::cfg_type cfg,
   output awc_pkg::range_status_type status
);

   logic [awc_pkg::COUNT_W-1:0] over_count_ff, over_count_in;
   logic signed [awc_pkg::SAMPLE_W-1:0] page_min_ff, page_min_in;
   logic signed [awc_pkg::SAMPLE_W-1:0] page_max_ff, page_max_in;
   logic page_start_ff, page_start_in;
   logic [awc_pkg::COOLDOWN_W-1:0] cooldown_ff, cooldown_in;

   logic signed [awc_pkg::SAMPLE_W:0] sample_ext;
   logic signed [awc_pkg::SAMPLE_W:0] level_pos;
   logic signed [awc_pkg::SAMPLE_W:0] level_neg;
   logic signed [awc_pkg::SAMPLE_W:0] span;
   logic outside;
   logic [awc_pkg::COUNT_W-1:0] count_base;
   logic signed [awc_pkg::SAMPLE_W-1:0] min_base;
   logic signed [awc_pkg::SAMPLE_W-1:0] max_base;
   logic [awc_pkg::COOLDOWN_W-1:0] cooldown_dec;
   logic report_over;
   logic report_under;

   always_comb begin
      sample_ext = {sample[awc_pkg::SAMPLE_W-1], sample};
      level_pos = signed'({2'b00, cfg.over_level});
      level_neg = -level_pos;
      outside = (sample_ext > level_pos) || (sample_ext < level_neg);

      count_base = page_start_ff ? '0 : over_count_ff;
      min_base = page_start_ff ? sample : page_min_ff;
      max_base = page_start_ff ? sample : page_max_ff;

      over_count_in = count_base;
      if (outside && (count_base != {awc_pkg::COUNT_W{1'b1}})) begin
         over_count_in = count_base + 1'b1;
      end
      page_max_in = (sample > max_base) ? sample : max_base;
      page_min_in = (sample < min_base) ? sample : min_base;

      span = {page_max_in[awc_pkg::SAMPLE_W-1], page_max_in}
           - {page_min_in[awc_pkg::SAMPLE_W-1], page_min_in};
      cooldown_dec = (cooldown_ff != '0) ? cooldown_ff - 1'b1 : cooldown_ff;

      report_over = (over_count_in > cfg.over_count_limit) && (cooldown_dec == '0);
      report_under = (unsigned'(span) < {1'b0, cfg.under_span})
                   && (cooldown_dec == '0);

      priority if (report_over) begin
         status = awc_pkg::STATUS_OVER;
      end else if (report_under) begin
         status = awc_pkg::STATUS_UNDER;
      end else begin
         status = awc_pkg::STATUS_NORMAL;
      end

      page_start_in = last;
      cooldown_in = cooldown_ff;
      if (last) begin
         cooldown_in = (report_over || report_under) ? cfg.cooldown_pages : cooldown_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         over_count_ff <= '0;
         page_min_ff <= '0;
         page_max_ff <= '0;
         page_start_ff <= 1'b1;
         cooldown_ff <= '0;
      end else if (step) begin
         over_count_ff <= over_count_in;
         page_min_ff <= page_min_in;
         page_max_ff <= page_max_in;
         page_start_ff <= page_start_in;
         cooldown_ff <= cooldown_in;
      end
   end

endmodule

// ===== rtl/autorange_window_check.sv =====
// Top level of the autorange window check block.
// Holds the configuration registers, the input register and the result register.
// Depends on awc_pkg and awc_page_track.
//
// The req channel carries one signed current sample per beat, with req_last set
// on the final sample of a page. The rsp channel carries one beat per page, the
// range status of that page: normal, overrange or underrange.
// Each accepted sample is held in the input register until it advances, then goes
// through the page state update; on a last sample the status is loaded into the
// result register, which raises rsp_valid for the status beat of that page.
// One sample is taken per cycle when the rsp side is not stalling.
// When the receiver stalls while a status waits, samples that are not last
// still pass through; a last sample waits in the input register and req_stall
// rises once that register is occupied and cannot advance.
// Reset clears the valid flags of both pipeline registers, loads the register
// defaults and opens a new page with the cooldown at zero.
// The csr port writes a register at every edge with csr_write_enable high;
// writes are meant to happen only while the block is idle.
module autorange_window_check (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [awc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_range_status,
   input  logic csr_write_enable,
   input  logic [awc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [awc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   awc_pkg::cfg_type cfg_ff;
   logic in_valid_ff;
   logic signed [awc_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic in_last_ff;
   logic rsp_valid_ff;
   awc_pkg::range_status_type rsp_status_ff;
   awc_pkg::range_status_type status;
   logic advance;
   logic req_take;
   logic rsp_take;

   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   awc_page_track u_page_track (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .sample(in_sample_ff),
      .last(in_last_ff),
      .cfg(cfg_ff),
      .status(status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.over_level <= awc_pkg::OVER_LEVEL_RESET;
         cfg_ff.under_span <= awc_pkg::UNDER_SPAN_RESET;
         cfg_ff.over_count_limit <= awc_pkg::OVER_COUNT_LIMIT_RESET;
         cfg_ff.cooldown_pages <= awc_pkg::COOLDOWN_PAGES_RESET;
      end else if (csr_write_enable) begin
         unique case (awc_pkg::reg_index_type'(csr_index))
            awc_pkg::REG_OVER_LEVEL: begin
               cfg_ff.over_level <= csr_wdata[awc_pkg::LEVEL_W-1:0];
            end
            awc_pkg::REG_UNDER_SPAN: begin
               cfg_ff.under_span <= csr_wdata[awc_pkg::SPAN_W-1:0];
            end
            awc_pkg::REG_OVER_COUNT_LIMIT: begin
               cfg_ff.over_count_limit <= csr_wdata[awc_pkg::LIMIT_W-1:0];
            end
            awc_pkg::REG_COOLDOWN_PAGES: begin
               cfg_ff.cooldown_pages <= csr_wdata[awc_pkg::COOLDOWN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample;
         in_last_ff <= req_last;
      end
      if (advance && in_last_ff) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_range_status = rsp_status_ff;

endmodule

// ===== dv/autorange_window_check_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for autorange_window_check: a scoreboard class predicts
// the range status of every page and checks each status beat against it.
// Depends on awc_pkg and the autorange_window_check RTL.
module autorange_window_check_test;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_SAMPLES = 24;
   localparam int LONG_PAGE = 1030;

   typedef enum int {PAGE_NOISE, PAGE_QUIET, PAGE_LOUD, PAGE_NEAR} page_kind_type;

   class range_scoreboard;
      logic [awc_pkg::LEVEL_W-1:0] over_level;
      logic [awc_pkg::SPAN_W-1:0] under_span;
      logic [awc_pkg::LIMIT_W-1:0] over_count_limit;
      logic [awc_pkg::COOLDOWN_W-1:0] cooldown_pages;
      logic [awc_pkg::COUNT_W-1:0] over_count;
      logic signed [awc_pkg::SAMPLE_W-1:0] page_min;
      logic signed [awc_pkg::SAMPLE_W-1:0] page_max;
      logic page_start;
      logic [awc_pkg::COOLDOWN_W-1:0] cooldown_left;
      awc_pkg::range_status_type pending[$];
      int unsigned errors;
      int unsigned pages;

      function new();
         over_level = awc_pkg::OVER_LEVEL_RESET;
         under_span = awc_pkg::UNDER_SPAN_RESET;
         over_count_limit = awc_pkg::OVER_COUNT_LIMIT_RESET;
         cooldown_pages = awc_pkg::COOLDOWN_PAGES_RESET;
         over_count = '0;
         page_min = '0;
         page_max = '0;
         page_start = 1'b1;
         cooldown_left = '0;
         errors = 0;
         pages = 0;
      endfunction

      function void write_reg(awc_pkg::reg_index_type idx,
                              logic [awc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            awc_pkg::REG_OVER_LEVEL: over_level = data[awc_pkg::LEVEL_W-1:0];
            awc_pkg::REG_UNDER_SPAN: under_span = data[awc_pkg::SPAN_W-1:0];
            awc_pkg::REG_OVER_COUNT_LIMIT: over_count_limit = data[awc_pkg::LIMIT_W-1:0];
            awc_pkg::REG_COOLDOWN_PAGES: cooldown_pages = data[awc_pkg::COOLDOWN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [awc_pkg::SAMPLE_W-1:0] value, logic last);
         int level;
         int span;
         awc_pkg::range_status_type status;
         level = int'(over_level);
         if (page_start) begin
            over_count = '0;
            page_min = value;
            page_max = value;
            page_start = 1'b0;
         end
         if ((value > level || value < -level) && over_count != '1) begin
            over_count = over_count + 1'b1;
         end
         if (value > page_max) page_max = value;
         if (value < page_min) page_min = value;
         if (last) begin
            page_start = 1'b1;
            if (cooldown_left != '0) cooldown_left = cooldown_left - 1'b1;
            span = int'(page_max) - int'(page_min);
            status = awc_pkg::STATUS_NORMAL;
            if (over_count > over_count_limit && cooldown_left == '0) begin
               status = awc_pkg::STATUS_OVER;
               cooldown_left = cooldown_pages;
            end else if (span < int'(under_span) && cooldown_left == '0) begin
               status = awc_pkg::STATUS_UNDER;
               cooldown_left = cooldown_pages;
            end
            pending.push_back(status);
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_status(logic [1:0] got);
         awc_pkg::range_status_type want;
         pages++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("status beat %0d (%0d) with no page pending", pages, got));
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("page %0d: status %0d, expected %s",
                                         pages, got, want.name()));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [awc_pkg::SAMPLE_W-1:0] req_sample;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_range_status;
   logic csr_write_enable;
   awc_pkg::reg_index_type csr_index;
   logic [awc_pkg::CSR_DATA_W-1:0] csr_wdata;

   range_scoreboard sb;
   int unsigned samples_sent;
   int unsigned quiet_cycles;
   bit sender_steady;
   bit hold_armed;
   bit hold_done;
   int hold_left;
   int boundary_samples[12] = '{32767, -32768, 1844, -1844, 1843, -1843, 0, -1, 1,
                                32767, -32768, 1844};

   autorange_window_check dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_range_status(rsp_range_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (req_valid && !req_stall) sb.note_sample(req_sample, req_last);
         if (rsp_valid && !rsp_stall) sb.check_status(rsp_range_status);
      end
   end

   initial begin
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("autorange_window_check_test failed");
      $finish;
   end

   // The receiver holds off once for a long stretch while samples keep coming, so the
   // block fills up and stalls its input. While the sender runs steady, it never stalls.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (sender_steady) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < 8);
         end
      end
   end

   task automatic send_sample(int value, bit last);
      @(negedge clock);
      while (!sender_steady && $urandom_range(99) < 8) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample = value[awc_pkg::SAMPLE_W-1:0];
      req_last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic send_page(int len, page_kind_type kind);
      int level;
      int spread;
      int base;
      int mag;
      int value;
      level = int'(sb.over_level);
      spread = $urandom_range(0, (sb.under_span > 65000) ? 65535 : int'(sb.under_span) + 4);
      base = $urandom_range(0, 65535 - spread) - 32768;
      for (int i = 0; i < len; i++) begin
         mag = 0;
         case (kind)
            PAGE_QUIET: value = base + $urandom_range(0, spread);
            PAGE_LOUD: begin
               if ($urandom_range(9) < 8) mag = level + 1 + $urandom_range(0, 400);
               else mag = $urandom_range(0, level);
               value = $urandom_range(1) ? -mag : mag;
            end
            PAGE_NEAR: begin
               mag = level - 1 + $urandom_range(0, 2);
               value = $urandom_range(1) ? -mag : mag;
            end
            default: value = $urandom_range(0, 65535) - 32768;
         endcase
         if (value > 32767) value = 32767;
         if (value < -32768) value = -32768;
         send_sample(value, i == len - 1);
      end
   endtask

   task automatic send_random_page();
      int r;
      int len;
      page_kind_type kind;
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 128);
      r = $urandom_range(99);
      if (r < 30) kind = PAGE_LOUD;
      else if (r < 60) kind = PAGE_QUIET;
      else if (r < 80) kind = PAGE_NOISE;
      else kind = PAGE_NEAR;
      send_page(len, kind);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_pages_for(int unsigned count);
      int unsigned stop_at;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) send_random_page();
      settle();
   endtask

   task automatic write_csr(awc_pkg::reg_index_type idx,
                            logic [awc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic write_config(logic [15:0] level_word, logic [15:0] span_word,
                               logic [15:0] limit_word, logic [15:0] cooldown_word);
      write_csr(awc_pkg::REG_OVER_LEVEL, level_word);
      write_csr(awc_pkg::REG_UNDER_SPAN, span_word);
      write_csr(awc_pkg::REG_OVER_COUNT_LIMIT, limit_word);
      write_csr(awc_pkg::REG_COOLDOWN_PAGES, cooldown_word);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic write_random_config();
      logic [15:0] level_word;
      logic [15:0] limit_word;
      if ($urandom_range(3) == 0) level_word = 16'($urandom);
      else level_word = 16'($urandom_range(0, 4000));
      level_word[15] = 1'($urandom_range(1));
      limit_word = {6'($urandom), 10'($urandom_range(0, 16))};
      write_config(level_word, 16'($urandom_range(0, 3000)), limit_word,
                   16'($urandom_range(0, 3)));
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = awc_pkg::REG_OVER_LEVEL;
      csr_wdata = '0;
      samples_sent = 0;
      quiet_cycles = 0;
      sender_steady = 1'b0;
      hold_armed = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values: a page around the level boundaries, a one-sample page, then a
      // loud page that the cooldown must suppress.
      for (int i = 0; i < 12; i++) send_sample(boundary_samples[i], i == 11);
      send_sample(0, 1'b1);
      for (int i = 0; i < 13; i++) send_sample((i % 2) ? -2000 : 2000, i == 12);
      settle();

      write_config(16'h8000, 16'h0000, 16'hFC00, 16'h0000);
      send_pages_for(PHASE_SAMPLES);

      for (int p = 0; p < 4; p++) begin
         sender_steady = (p == 1);
         write_random_config();
         send_pages_for(PHASE_SAMPLES);
      end
      sender_steady = 1'b0;

      // The receiver holds off from the first of these short pages, so the second
      // last sample fills the block and the rest wait at the input.
      hold_armed = 1'b1;
      repeat (6) send_page(4, PAGE_NOISE);
      settle();

      // One long page drives the overrange count into saturation, with no idling.
      sender_steady = 1'b1;
      write_config(16'd100, 16'd0, 16'd1022, 16'd0);
      repeat (4) send_sample(0, 1'b1);
      for (int i = 0; i < LONG_PAGE; i++) begin
         send_sample((i % 2) ? -(200 + i) : 200 + i, i == LONG_PAGE - 1);
      end
      settle();
      sender_steady = 1'b0;

      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (4) send_random_page();
      settle();

      if (sb.errors == 0) begin
         $display("autorange_window_check_test passed");
      end else begin
         $display("autorange_window_check_test failed");
      end
      $finish;
   end
endmodule
